// File: hw/rtl/dpb_pkg.sv
// Shared constants for the depth pixel back-projection block.
// Register indexes, field widths, reset values and output limits.
// Depends on nothing; used by depth_pixel_backprojection.
package dpb_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKEW_RATIO  = 3'd4;

	// Field widths
	localparam int RECIP_W  = 24;
	localparam int CENTRE_W = 16;
	localparam int SKEW_W   = 24;
	localparam int DEPTH_W  = 16;
	localparam int OUT_W    = 23;

	// Register values after reset
	localparam logic [RECIP_W-1:0]         INV_FOCAL_RST = 24'd29127;
	localparam logic [CENTRE_W-1:0]        CENTRE_X_RST  = 16'd5120;
	localparam logic [CENTRE_W-1:0]        CENTRE_Y_RST  = 16'd3840;
	localparam logic signed [SKEW_W-1:0]   SKEW_RST      = 24'sd0;

	// Saturation limits of the lateral outputs
	localparam logic signed [OUT_W-1:0] OUT_MAX = 23'sh3FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 23'sh400000;

endpackage

// File: hw/rtl/depth_pixel_backprojection.sv
// Pinhole camera back-projection of depth pixels with skew, eight stage pipeline.
// Uses constants from dpb_pkg (register indexes, widths, reset values, limits).
// Top level of the block; no submodules.

// The block takes one depth pixel per clock while the output is not stalled and
// returns its camera-frame point, x and y in sixteenths of a millimetre (saturated)
// and z in millimetres. Throughput is one beat per cycle while the output is not
// stalled; the pipeline depth is set by the x path: offsets, the skew product, the
// skew correction, a rounding step, and two wide products (inverse focal length,
// depth) that are each split into two narrow partial products and recombined with
// rounding in the following stage. A beat with keep low is accepted but leaves
// no result; a zero depth gives a result with point_valid low and zero
// coordinates. Each stage is stalled only while it is full and the one after it
// cannot take data, so in_ready follows out_ready combinationally through the
// chain of stage enables. Registers may only be written while the pipeline is empty.
module depth_pixel_backprojection #(
	parameter int COORD_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port
	input  logic                                  cfg_we,
	input  logic [dpb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dpb_pkg::CFG_DATA_W-1:0]        cfg_data,
	// Pixel input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [COORD_BITS-1:0]                 pixel_col,
	input  logic [COORD_BITS-1:0]                 pixel_row,
	input  logic [dpb_pkg::DEPTH_W-1:0]           depth_mm,
	input  logic                                  keep,
	// Point output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [dpb_pkg::OUT_W-1:0]      point_x,
	output logic signed [dpb_pkg::OUT_W-1:0]      point_y,
	output logic [dpb_pkg::DEPTH_W-1:0]           point_z,
	output logic                                  point_valid
);

	// Derived widths
	localparam int SPAN = ((COORD_BITS + 4) > dpb_pkg::CENTRE_W) ?
		(COORD_BITS + 4) : dpb_pkg::CENTRE_W;
	localparam int DW   = SPAN + 1;                // du, dv (signed, 1/16 pixel)
	localparam int PAW  = DW + dpb_pkg::SKEW_W;    // skew * dv
	localparam int AW   = DW + 25;                 // a = du*2^20 - skew*dv
	localparam int HW   = AW - 3;                  // h = round(a, 4)
	localparam int XHW  = DW + 27;                 // upper h part * inv_focal_x
	localparam int NW   = DW + 28;                 // n = round(h*ifx, 20)
	localparam int ZHW  = DW + 25;                 // upper n part * z
	localparam int XW   = DW + 26;                 // x before saturation
	localparam int PYW  = DW + 25;                 // dv * inv_focal_y
	localparam int YHW  = DW + 18;                 // upper py part * z
	localparam int YW   = DW + 19;                 // y before saturation
	localparam int RW   = dpb_pkg::RECIP_W;
	localparam int ZW   = dpb_pkg::DEPTH_W;
	localparam int OW   = dpb_pkg::OUT_W;

	// Configuration registers
	logic [RW-1:0]                       inv_focal_x_q;
	logic [RW-1:0]                       inv_focal_y_q;
	logic [dpb_pkg::CENTRE_W-1:0]        centre_x_q;
	logic [dpb_pkg::CENTRE_W-1:0]        centre_y_q;
	logic signed [dpb_pkg::SKEW_W-1:0]   skew_ratio_q;

	// Stage enables and valid bits
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// Stage 1
	logic signed [DW-1:0]   du_s1, dv_s1;
	logic [ZW-1:0]          z_s1;
	// Stage 2
	logic signed [DW-1:0]   du_s2;
	logic signed [PAW-1:0]  pa_s2;
	logic signed [PYW-1:0]  py_s2;
	logic [ZW-1:0]          z_s2;
	// Stage 3
	logic signed [AW-1:0]   a_s3;
	logic [RW+ZW-1:0]       ylo_s3;
	logic signed [YHW-1:0]  yhi_s3;
	logic                   yneg_s3;
	logic [ZW-1:0]          z_s3;
	// Stage 4
	logic signed [HW-1:0]   h_s4;
	logic signed [OW-1:0]   y_s4;
	logic [ZW-1:0]          z_s4;
	// Stage 5
	logic [20+RW-1:0]       xlo_s5;
	logic signed [XHW-1:0]  xhi_s5;
	logic                   xneg_s5;
	logic signed [OW-1:0]   y_s5;
	logic [ZW-1:0]          z_s5;
	// Stage 6
	logic signed [NW-1:0]   n_s6;
	logic signed [OW-1:0]   y_s6;
	logic [ZW-1:0]          z_s6;
	// Stage 7
	logic [20+ZW-1:0]       zlo_s7;
	logic signed [ZHW-1:0]  zhi_s7;
	logic                   nneg_s7;
	logic signed [OW-1:0]   y_s7;
	logic [ZW-1:0]          z_s7;
	// Stage 8 (output register)
	logic signed [OW-1:0]   x_s8, y_s8;
	logic [ZW-1:0]          z_s8;
	logic                   pv_s8;

	// Combinational results feeding the stage registers
	logic signed [DW-1:0]   du_c, dv_c;
	logic signed [PAW-1:0]  pa_c;
	logic signed [PYW-1:0]  py_c;
	logic signed [AW-1:0]   a_c;
	logic [RW+ZW-1:0]       ylo_c;
	logic signed [YHW-1:0]  yhi_c;
	logic [AW:0]            hsum_c;
	logic [RW+ZW:0]         ysum_c;
	logic signed [YW-1:0]   y_c;
	logic signed [OW-1:0]   ysat_c;
	logic [20+RW-1:0]       xlo_c;
	logic signed [XHW-1:0]  xhi_c;
	logic [20+RW:0]         xsum_c;
	logic signed [NW-1:0]   n_c;
	logic [20+ZW-1:0]       zlo_c;
	logic signed [ZHW-1:0]  zhi_c;
	logic [20+ZW:0]         zsum_c;
	logic signed [XW-1:0]   x_c;
	logic signed [OW-1:0]   xsat_c;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_x_q <= dpb_pkg::INV_FOCAL_RST;
			inv_focal_y_q <= dpb_pkg::INV_FOCAL_RST;
			centre_x_q    <= dpb_pkg::CENTRE_X_RST;
			centre_y_q    <= dpb_pkg::CENTRE_Y_RST;
			skew_ratio_q  <= dpb_pkg::SKEW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dpb_pkg::REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data[RW-1:0];
				dpb_pkg::REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data[RW-1:0];
				dpb_pkg::REG_CENTRE_X:    centre_x_q <= cfg_data[dpb_pkg::CENTRE_W-1:0];
				dpb_pkg::REG_CENTRE_Y:    centre_y_q <= cfg_data[dpb_pkg::CENTRE_W-1:0];
				dpb_pkg::REG_SKEW_RATIO:  skew_ratio_q <= $signed(cfg_data[dpb_pkg::SKEW_W-1:0]);
				default: ;
			endcase
		end
	end

	// Stall chain: a stage loads when it is empty or its contents move on.
	assign adv_s8   = !vld_s8 || out_ready;
	assign adv_s7   = !vld_s7 || adv_s8;
	assign adv_s6   = !vld_s6 || adv_s7;
	assign adv_s5   = !vld_s5 || adv_s6;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Valid bits; a beat with keep low enters as a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid && keep;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
			if (adv_s8) vld_s8 <= vld_s7;
		end
	end

	// Stage 1: offsets from the principal point in sixteenths of a pixel.
	assign du_c = $signed(DW'({pixel_col, 4'b0000})) - $signed(DW'(centre_x_q));
	assign dv_c = $signed(DW'({pixel_row, 4'b0000})) - $signed(DW'(centre_y_q));

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			du_s1 <= du_c;
			dv_s1 <= dv_c;
			z_s1  <= depth_mm;
		end
	end

	// Stage 2: skew term and the y product with the inverse focal length.
	assign pa_c = PAW'(dv_s1) * PAW'(skew_ratio_q);
	assign py_c = PYW'(dv_s1) * PYW'($signed({1'b0, inv_focal_y_q}));

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			du_s2 <= du_s1;
			pa_s2 <= pa_c;
			py_s2 <= py_c;
			z_s2  <= z_s1;
		end
	end

	// Stage 3: skew-corrected column term; y times depth as two partial products.
	assign a_c   = (AW'(du_s2) <<< 20) - AW'(pa_s2);
	assign ylo_c = py_s2[RW-1:0] * z_s2;
	assign yhi_c = YHW'($signed(py_s2[PYW-1:RW])) * YHW'($signed({1'b0, z_s2}));

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			a_s3    <= a_c;
			ylo_s3  <= ylo_c;
			yhi_s3  <= yhi_c;
			yneg_s3 <= py_s2[PYW-1];
			z_s3    <= z_s2;
		end
	end

	// Stage 4: round a by 4 bits, half away from zero; finish and saturate y.
	assign hsum_c = {a_s3[AW-1], a_s3} + (AW+1)'(8) - (AW+1)'(a_s3[AW-1]);
	assign ysum_c = {1'b0, ylo_s3} + (RW+ZW+1)'(1 << (RW-1)) - (RW+ZW+1)'(yneg_s3);
	assign y_c    = YW'(yhi_s3) + YW'($signed({1'b0, ysum_c[RW+ZW:RW]}));

	always_comb begin
		if (y_c > YW'(dpb_pkg::OUT_MAX)) begin
			ysat_c = dpb_pkg::OUT_MAX;
		end else if (y_c < YW'(dpb_pkg::OUT_MIN)) begin
			ysat_c = dpb_pkg::OUT_MIN;
		end else begin
			ysat_c = y_c[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			h_s4 <= $signed(hsum_c[AW:4]);
			y_s4 <= ysat_c;
			z_s4 <= z_s3;
		end
	end

	// Stage 5: h times inv_focal_x, split at bit 20 of h.
	assign xlo_c = h_s4[19:0] * inv_focal_x_q;
	assign xhi_c = XHW'($signed(h_s4[HW-1:20])) * XHW'($signed({1'b0, inv_focal_x_q}));

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			xlo_s5  <= xlo_c;
			xhi_s5  <= xhi_c;
			xneg_s5 <= h_s4[HW-1];
			y_s5    <= y_s4;
			z_s5    <= z_s4;
		end
	end

	// Stage 6: recombine and round by 20 bits.
	assign xsum_c = {1'b0, xlo_s5} + (20+RW+1)'(1 << 19) - (20+RW+1)'(xneg_s5);
	assign n_c    = NW'(xhi_s5) + NW'($signed({1'b0, xsum_c[20+RW:20]}));

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			n_s6 <= n_c;
			y_s6 <= y_s5;
			z_s6 <= z_s5;
		end
	end

	// Stage 7: n times depth, split at bit 20 of n.
	assign zlo_c = n_s6[19:0] * z_s6;
	assign zhi_c = ZHW'($signed(n_s6[NW-1:20])) * ZHW'($signed({1'b0, z_s6}));

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			zlo_s7  <= zlo_c;
			zhi_s7  <= zhi_c;
			nneg_s7 <= n_s6[NW-1];
			y_s7    <= y_s6;
			z_s7    <= z_s6;
		end
	end

	// Stage 8: round x by 20 bits and saturate; zero depth clears the point.
	assign zsum_c = {1'b0, zlo_s7} + (20+ZW+1)'(1 << 19) - (20+ZW+1)'(nneg_s7);
	assign x_c    = XW'(zhi_s7) + XW'($signed({1'b0, zsum_c[20+ZW:20]}));

	always_comb begin
		if (x_c > XW'(dpb_pkg::OUT_MAX)) begin
			xsat_c = dpb_pkg::OUT_MAX;
		end else if (x_c < XW'(dpb_pkg::OUT_MIN)) begin
			xsat_c = dpb_pkg::OUT_MIN;
		end else begin
			xsat_c = x_c[OW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			x_s8  <= (z_s7 != '0) ? xsat_c : '0;
			y_s8  <= (z_s7 != '0) ? y_s7 : '0;
			z_s8  <= z_s7;
			pv_s8 <= (z_s7 != '0);
		end
	end

	// Output channel
	assign out_valid   = vld_s8;
	assign point_x     = x_s8;
	assign point_y     = y_s8;
	assign point_z     = z_s8;
	assign point_valid = pv_s8;

	// A delivered point is flagged valid exactly when its depth is nonzero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_valid == (point_z != '0)))
		else $error("point_valid disagrees with point_z");

	// A point without a depth measurement carries zero coordinates.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !point_valid) |-> (point_x == '0 && point_y == '0))
		else $error("invalid point has nonzero coordinates");

	// An accepted beat enters the first stage as a result only if its mask bit is set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (vld_s1 == $past(keep)))
		else $error("first stage valid does not follow the mask bit");

	// The input is held off only while the first stage is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1)
		else $error("input stalled with an empty first stage");

endmodule
